/* hdl/sxfr_pkg.sv */
// ----------------------------------------------------------------------------
// sxfr_pkg
// Shared types and constants of the sync/xor frame receiver.
// ----------------------------------------------------------------------------
package sxfr_pkg;

	localparam int MAX_PAYLOAD_DEF = 16;

	localparam int BYTE_W  = 8;
	localparam int LEN_W   = 5;
	localparam int INDEX_W = 4;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [BYTE_W-1:0] FIRST_SYNC_RST  = 8'hAA;
	localparam logic [BYTE_W-1:0] SECOND_SYNC_RST = 8'hCC;
	localparam logic [LEN_W-1:0]  PAYLOAD_LEN_RST = 5'd16;

	// input command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_SYNC2 = 2'd1,
		PH_DATA  = 2'd2
	} phase_t;

	// register index, taken from the word address
	typedef enum logic [1:0] {
		REG_FIRST_SYNC  = 2'd0,
		REG_SECOND_SYNC = 2'd1,
		REG_PAYLOAD_LEN = 2'd2
	} reg_idx_t;

endpackage

/* hdl/sxfr_if.sv */
// ----------------------------------------------------------------------------
// sxfr_if
// Valid/ready channels for received bytes and emitted payload words.
// ----------------------------------------------------------------------------
interface sxfr_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	logic       line_error;

	modport source (output valid, cmd, rx_byte, line_error, input ready);
	modport sink   (input valid, cmd, rx_byte, line_error, output ready);
endinterface

interface sxfr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic [3:0] byte_index;
	logic       last;

	modport source (output valid, payload_byte, byte_index, last, input ready);
	modport sink   (input valid, payload_byte, byte_index, last, output ready);
endinterface

/* hdl/sxfr_cell.sv */
// ----------------------------------------------------------------------------
// sxfr_cell
// One payload byte cell: loaded at its own position, shifts toward cell 0.
// ----------------------------------------------------------------------------
module sxfr_cell (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic                      shift_en,
	input  logic [sxfr_pkg::BYTE_W-1:0] wr_data,
	input  logic [sxfr_pkg::BYTE_W-1:0] nbr_data,
	output logic [sxfr_pkg::BYTE_W-1:0] data
);
	import sxfr_pkg::*;

	logic [BYTE_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			data_q <= wr_data;
		end else if (shift_en) begin
			data_q <= nbr_data;
		end
	end

	assign data = data_q;
endmodule

/* hdl/sync_xor_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// sync_xor_frame_receiver_top
// Hunts two sync bytes, buffers the payload in a row of byte cells, checks
// the xor checksum and emits the payload one word per cycle while the sink is ready.
// ----------------------------------------------------------------------------
// timing: a byte or ack is taken on a valid/ready handshake; the accepted
//   checksum byte starts emission: cell 0 is loaded into the output register
// throughput: one input word per cycle while ready; after a good frame the
//   input is held (ready low) while the cell row shifts the payload out,
//   and the sink can stall that shifting
// reset: arst_n resets parser, pending flag, registers; cells are not reset
module sync_xor_frame_receiver_top #(
	parameter int MAX_PAYLOAD = sxfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	sxfr_in_if.sink                       in_ch,
	sxfr_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sxfr_pkg::ADDR_W-1:0]   paddr,
	input  logic [sxfr_pkg::DATA_W-1:0]   pwdata,
	output logic [sxfr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import sxfr_pkg::*;

	localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
	localparam int POS_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	// configuration registers
	logic [BYTE_W-1:0] first_sync_q;
	logic [BYTE_W-1:0] second_sync_q;
	logic [LEN_W-1:0]  payload_len_q;
	reg_idx_t          reg_idx;
	logic              cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_sync_q  <= FIRST_SYNC_RST;
			second_sync_q <= SECOND_SYNC_RST;
			payload_len_q <= PAYLOAD_LEN_RST;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_FIRST_SYNC:  first_sync_q  <= pwdata[BYTE_W-1:0];
				REG_SECOND_SYNC: second_sync_q <= pwdata[BYTE_W-1:0];
				REG_PAYLOAD_LEN: payload_len_q <= pwdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_FIRST_SYNC:  prdata = DATA_W'(first_sync_q);
			REG_SECOND_SYNC: prdata = DATA_W'(second_sync_q);
			REG_PAYLOAD_LEN: prdata = DATA_W'(payload_len_q);
			default:         prdata = '0;
		endcase
	end

	// parser state
	phase_t            phase_q, phase_d;
	logic [CNT_W-1:0]  bytes_left_q;
	logic [BYTE_W-1:0] xor_q;
	logic [CNT_W-1:0]  wpos_q;
	logic              pending_q;

	// emission state
	logic [CNT_W-1:0]  emit_left_q;
	logic [CNT_W-1:0]  emit_idx_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic              out_last_q;

	logic              in_fire;
	logic              byte_ok;
	logic              sync1_hit;
	logic              sync2_hit;
	logic              store_en;
	logic              frame_good;
	logic              emit_load;
	logic [CNT_W-1:0]  len_clamped;

	assign in_ch.ready = (emit_left_q == '0);
	assign in_fire     = in_ch.valid & in_ch.ready;
	assign byte_ok     = in_fire & (in_ch.cmd == CMD_BYTE) & ~in_ch.line_error;

	// length latched at second sync: zero means one, capped at buffer depth
	always_comb begin
		if (payload_len_q == '0) begin
			len_clamped = CNT_W'(1);
		end else if (32'(payload_len_q) > 32'(MAX_PAYLOAD)) begin
			len_clamped = CNT_W'(MAX_PAYLOAD);
		end else begin
			len_clamped = CNT_W'(payload_len_q);
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (byte_ok) begin
			case (phase_q)
				PH_SYNC2: phase_d = (in_ch.rx_byte == second_sync_q) ? PH_DATA : PH_HUNT;
				PH_DATA:  phase_d = (bytes_left_q != '0) ? PH_DATA : PH_HUNT;
				default:  phase_d = (in_ch.rx_byte == first_sync_q) ? PH_SYNC2 : PH_HUNT;
			endcase
		end
	end

	always_comb begin
		sync1_hit  = 1'b0;
		sync2_hit  = 1'b0;
		store_en   = 1'b0;
		frame_good = 1'b0;
		if (byte_ok) begin
			case (phase_q)
				PH_SYNC2: sync2_hit = (in_ch.rx_byte == second_sync_q);
				PH_DATA: begin
					store_en   = (bytes_left_q != '0);
					frame_good = (bytes_left_q == '0) & (in_ch.rx_byte == xor_q) & ~pending_q;
				end
				default:  sync1_hit = (in_ch.rx_byte == first_sync_q);
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT;
			bytes_left_q <= '0;
			xor_q        <= '0;
			wpos_q       <= '0;
			pending_q    <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (sync1_hit) begin
				xor_q <= in_ch.rx_byte;
			end
			if (sync2_hit) begin
				xor_q        <= xor_q ^ in_ch.rx_byte;
				bytes_left_q <= len_clamped;
				wpos_q       <= '0;
			end
			if (store_en) begin
				xor_q        <= xor_q ^ in_ch.rx_byte;
				bytes_left_q <= bytes_left_q - CNT_W'(1);
				wpos_q       <= wpos_q + CNT_W'(1);
			end
			if (in_fire && in_ch.cmd == CMD_ACK) begin
				pending_q <= 1'b0;
			end else if (frame_good) begin
				pending_q <= 1'b1;
			end
		end
	end

	// row of byte cells; cell 0 feeds the output register
	logic [BYTE_W-1:0] cell_data [MAX_PAYLOAD];

	for (genvar i = 0; i < MAX_PAYLOAD; i++) begin : g_cell
		logic [BYTE_W-1:0] nbr;
		if (i == MAX_PAYLOAD - 1) begin : g_end
			assign nbr = cell_data[i];
		end else begin : g_mid
			assign nbr = cell_data[i+1];
		end
		sxfr_cell u_cell (
			.clk      (clk),
			.wr_en    (store_en && (wpos_q[POS_W-1:0] == POS_W'(i))),
			.shift_en (emit_load),
			.wr_data  (in_ch.rx_byte),
			.nbr_data (nbr),
			.data     (cell_data[i])
		);
	end

	assign emit_load = (emit_left_q != '0) & (~out_valid_q | out_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_left_q <= '0;
			emit_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (frame_good) begin
				emit_left_q <= wpos_q;
				emit_idx_q  <= '0;
			end else if (emit_load) begin
				emit_left_q <= emit_left_q - CNT_W'(1);
				emit_idx_q  <= emit_idx_q + CNT_W'(1);
			end
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_byte_q <= cell_data[0];
			out_idx_q  <= INDEX_W'(emit_idx_q);
			out_last_q <= (emit_left_q == CNT_W'(1));
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.payload_byte = out_byte_q;
	assign out_ch.byte_index   = out_idx_q;
	assign out_ch.last         = out_last_q;
endmodule
